FILE: src/assert_macros.svh
// Concurrent assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: src/hvn_pkg.sv
// Shared types and constants of the heightmap vertex normal pipeline.
package hvn_pkg;

  // Gradient divider: num = 2|diff|*256 + |span|, den = 2|span|
  localparam int GNUM_W  = 26;
  localparam int GDEN_W  = 17;
  localparam int GRAD_QW = 16;
  localparam int GNUM_SH = 9;

  // Square root of S * 2^30, S is Q16.16 and below 2^32
  localparam int SQ_W    = 32;
  localparam int ROOT_W  = 31;

  // Normal dividers: num = 2|g|*2^29 + r or 2*2^37 + r, den = 2r
  localparam int NNUM_W  = 47;
  localparam int NDEN_W  = 32;
  localparam int NQ_W    = 15;
  localparam int NX_SH   = 30;
  localparam int NY_SH   = 38;

  localparam logic [15:0]     GRAD_POS_LIM = 16'h7FFF;
  localparam logic [15:0]     GRAD_NEG_LIM = 16'h8000;
  localparam logic [SQ_W-1:0] ONE_Q16      = 32'h0001_0000;
  localparam logic [NQ_W-1:0] UNIT_Q14     = 15'd16384;

  typedef struct packed {
    logic neg;
    logic zero;
  } grad_side_t;

  typedef struct packed {
    logic signed [15:0] dx;
    logic signed [15:0] dz;
    logic               sat;
  } norm_side_t;

endpackage

FILE: src/hvn_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module hvn_div #(
  parameter int NW = 26,
  parameter int DW = 17,
  parameter int QW = 16,
  parameter int SW = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side,
  output logic          out_vld,
  output logic [QW-1:0] quot,
  output logic          ovf,
  output logic [SW-1:0] side_o
);
  localparam int W = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic [W-1:0]  rem_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [QW-1:0] quo_r  [QW];
  logic [QW-1:0] ovf_r;
  logic [SW-1:0] side_r [QW];
  logic [QW-1:0] vld_r;

  logic [W-1:0]  rem_p  [QW];
  logic [DW-1:0] den_p  [QW];
  logic [QW-1:0] quo_p  [QW];
  logic [QW-1:0] ovf_p;
  logic [SW-1:0] side_p [QW];
  logic [QW-1:0] vld_p;
  logic [W-1:0]  sh     [QW];
  logic [QW-1:0] ge;
  logic [W-1:0]  rem_nxt [QW];
  logic [QW-1:0] quo_nxt [QW];
  logic          ovf_in;

  // quotient does not fit in QW bits
  assign ovf_in = W'(num) >= (W'(den) << QW);

  // one trial subtract per stage
  always_comb begin
    rem_p[0]  = W'(num);
    den_p[0]  = den;
    quo_p[0]  = '0;
    ovf_p[0]  = ovf_in;
    side_p[0] = side;
    vld_p[0]  = in_vld;
    for (int i = 1; i < QW; i++) begin
      rem_p[i]  = rem_r[i-1];
      den_p[i]  = den_r[i-1];
      quo_p[i]  = quo_r[i-1];
      ovf_p[i]  = ovf_r[i-1];
      side_p[i] = side_r[i-1];
      vld_p[i]  = vld_r[i-1];
    end
    for (int i = 0; i < QW; i++) begin
      sh[i]      = W'(den_p[i]) << (QW - 1 - i);
      ge[i]      = rem_p[i] >= sh[i];
      rem_nxt[i] = ge[i] ? rem_p[i] - sh[i] : rem_p[i];
      quo_nxt[i] = quo_p[i] | (QW'(ge[i]) << (QW - 1 - i));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_p;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r <= ovf_p;
      for (int i = 0; i < QW; i++) begin
        rem_r[i]  <= rem_nxt[i];
        den_r[i]  <= den_p[i];
        quo_r[i]  <= quo_nxt[i];
        side_r[i] <= side_p[i];
      end
    end
  end

  assign out_vld = vld_r[QW-1];
  assign quot    = quo_r[QW-1];
  assign ovf     = ovf_r[QW-1];
  assign side_o  = side_r[QW-1];

endmodule

FILE: src/hvn_sqrt.sv
// Pipelined digit-by-digit square root of S * 2^30, one root bit per stage.
module hvn_sqrt #(
  parameter int SW = 33
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic [hvn_pkg::SQ_W-1:0]  rad,
  input  logic [SW-1:0]             side,
  output logic                      out_vld,
  output logic [hvn_pkg::ROOT_W-1:0] root,
  output logic [SW-1:0]             side_o
);
  localparam int N  = hvn_pkg::ROOT_W;
  localparam int RW = hvn_pkg::ROOT_W + 3;
  localparam int QW = hvn_pkg::SQ_W;

  logic [RW-1:0] rem_r  [N];
  logic [N-1:0]  root_r [N];
  logic [QW-1:0] s_r    [N];
  logic [SW-1:0] side_r [N];
  logic [N-1:0]  vld_r;

  logic [RW-1:0] rem_p  [N];
  logic [N-1:0]  root_p [N];
  logic [QW-1:0] s_p    [N];
  logic [SW-1:0] side_p [N];
  logic [N-1:0]  vld_p;
  logic [RW-1:0] trial  [N];
  logic [RW-1:0] sub    [N];
  logic [N-1:0]  ge;
  logic [RW-1:0] rem_nxt  [N];
  logic [N-1:0]  root_nxt [N];
  logic [QW-1:0] s_nxt    [N];

  // bring down two radicand bits per stage; the low 30 bits are zero
  always_comb begin
    rem_p[0]  = '0;
    root_p[0] = '0;
    s_p[0]    = rad;
    side_p[0] = side;
    vld_p[0]  = in_vld;
    for (int i = 1; i < N; i++) begin
      rem_p[i]  = rem_r[i-1];
      root_p[i] = root_r[i-1];
      s_p[i]    = s_r[i-1];
      side_p[i] = side_r[i-1];
      vld_p[i]  = vld_r[i-1];
    end
    for (int i = 0; i < N; i++) begin
      trial[i]    = {rem_p[i][RW-3:0], s_p[i][QW-1:QW-2]};
      sub[i]      = RW'({root_p[i], 2'b01});
      ge[i]       = trial[i] >= sub[i];
      rem_nxt[i]  = ge[i] ? trial[i] - sub[i] : trial[i];
      root_nxt[i] = {root_p[i][N-2:0], ge[i]};
      s_nxt[i]    = s_p[i] << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_p;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        rem_r[i]  <= rem_nxt[i];
        root_r[i] <= root_nxt[i];
        s_r[i]    <= s_nxt[i];
        side_r[i] <= side_p[i];
      end
    end
  end

  assign out_vld = vld_r[N-1];
  assign root    = root_r[N-1];
  assign side_o  = side_r[N-1];

endmodule

FILE: src/heightmap_vertex_normal.sv
// Heightmap vertex normal by central differences: top level pipeline.
// Stages: 2 prep stages, 16-stage gradient divide, 3 stages square/sum,
// 31-stage square root, 1 prep, 15-stage normal divide, 1 output register.
// Throughput: one beat per cycle while out_stall does not hold the pipe.
// All stages advance together; an output beat held by out_stall holds the pipe.
// Synchronous active-low reset clears all valid bits; payload is not reset.
`include "assert_macros.svh"

module heightmap_vertex_normal (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_height_left,
  input  logic signed [15:0] in_height_right,
  input  logic signed [15:0] in_height_down,
  input  logic signed [15:0] in_height_up,
  input  logic signed [15:0] in_span_x,
  input  logic signed [15:0] in_span_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_normal_x,
  output logic [14:0]        out_normal_y,
  output logic signed [15:0] out_normal_z,
  output logic               out_slope_saturated
);

  typedef struct packed {
    logic signed [15:0] g;
    logic               sat;
  } grad_res_t;

  localparam int GSW = $bits(hvn_pkg::grad_side_t);
  localparam int NSW = $bits(hvn_pkg::norm_side_t);

  logic en;

  // Stage A: height differences
  logic               a_vld_r;
  logic signed [16:0] a_dhx_r, a_dhz_r;
  logic signed [15:0] a_sx_r, a_sz_r;

  // Stage B: divider operands
  logic                              b_vld_r;
  logic [hvn_pkg::GNUM_W-1:0]        b_numx_r, b_numz_r;
  logic [hvn_pkg::GDEN_W-1:0]        b_denx_r, b_denz_r;
  hvn_pkg::grad_side_t               b_sidex_r, b_sidez_r;
  logic signed [16:0]                absdx, absdz, absx17, absz17;
  logic [15:0]                       adx, adz, asx, asz;

  // gradient divider outputs
  logic                       gx_vld, gz_vld, gx_ovf, gz_ovf;
  logic [hvn_pkg::GRAD_QW-1:0] gx_q, gz_q;
  hvn_pkg::grad_side_t        gx_side, gz_side;
  grad_res_t                  gx_res, gz_res;

  // Stage C: saturated gradients
  logic               c_vld_r, c_sat_r;
  logic signed [15:0] c_dx_r, c_dz_r;

  // Stage D: squares
  logic               d_vld_r, d_sat_r;
  logic signed [15:0] d_dx_r, d_dz_r;
  logic [30:0]        d_sqx_r, d_sqz_r;
  logic signed [31:0] sqx, sqz;

  // Stage E: squared length
  logic                     e_vld_r;
  logic [hvn_pkg::SQ_W-1:0] e_s_r;
  hvn_pkg::norm_side_t      e_side_r;

  // square root outputs
  logic                        sq_vld;
  logic [hvn_pkg::ROOT_W-1:0]  sq_root;
  hvn_pkg::norm_side_t         sq_side;

  // Stage F: normal divider operands
  logic                       f_vld_r, f_negx_r, f_negz_r, f_sat_r;
  logic [hvn_pkg::NNUM_W-1:0] f_numx_r, f_numz_r, f_numy_r;
  logic [hvn_pkg::NDEN_W-1:0] f_den_r;
  logic signed [16:0]         gxe, gze, agx17, agz17;

  // normal divider outputs
  logic                      nx_vld, ny_vld, nz_vld;
  logic [hvn_pkg::NQ_W-1:0]  nx_q, ny_q, nz_q;
  logic                      nx_neg, nz_neg, ny_sat;
  logic                      nx_ovf, ny_ovf, nz_ovf;
  logic [hvn_pkg::NQ_W-1:0]  cx, cy, cz;

  // output register
  logic               out_valid_r, out_sat_r;
  logic signed [15:0] out_nx_r, out_nz_r;
  logic [14:0]        out_ny_r;

  // whole pipe moves unless a held output beat is stalled
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  function automatic grad_res_t grad_sat(input logic [15:0] q, input logic ovf,
                                         input hvn_pkg::grad_side_t sd);
    grad_res_t          res;
    logic signed [16:0] negq;
    negq    = -$signed({1'b0, q});
    res.g   = '0;
    res.sat = 1'b0;
    if (sd.zero) begin
      res.g = '0;
    end else if (sd.neg) begin
      if (ovf || q > hvn_pkg::GRAD_NEG_LIM) begin
        res.g   = hvn_pkg::GRAD_NEG_LIM;
        res.sat = 1'b1;
      end else begin
        res.g = negq[15:0];
      end
    end else begin
      if (ovf || q > hvn_pkg::GRAD_POS_LIM) begin
        res.g   = hvn_pkg::GRAD_POS_LIM;
        res.sat = 1'b1;
      end else begin
        res.g = q;
      end
    end
    return res;
  endfunction

  function automatic logic [hvn_pkg::NQ_W-1:0] clamp_unit(input logic [hvn_pkg::NQ_W-1:0] q);
    return (q > hvn_pkg::UNIT_Q14) ? hvn_pkg::UNIT_Q14 : q;
  endfunction

  // Stage A
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_dhx_r <= 17'(in_height_right) - 17'(in_height_left);
      a_dhz_r <= 17'(in_height_up) - 17'(in_height_down);
      a_sx_r  <= in_span_x;
      a_sz_r  <= in_span_z;
    end
  end

  // Stage B: magnitudes, rounding bias folded into the numerator
  always_comb begin
    absdx  = a_dhx_r[16] ? -a_dhx_r : a_dhx_r;
    absdz  = a_dhz_r[16] ? -a_dhz_r : a_dhz_r;
    absx17 = a_sx_r[15] ? -17'(a_sx_r) : 17'(a_sx_r);
    absz17 = a_sz_r[15] ? -17'(a_sz_r) : 17'(a_sz_r);
    adx    = absdx[15:0];
    adz    = absdz[15:0];
    asx    = absx17[15:0];
    asz    = absz17[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_numx_r       <= (hvn_pkg::GNUM_W'(adx) << hvn_pkg::GNUM_SH) + hvn_pkg::GNUM_W'(asx);
      b_numz_r       <= (hvn_pkg::GNUM_W'(adz) << hvn_pkg::GNUM_SH) + hvn_pkg::GNUM_W'(asz);
      b_denx_r       <= {asx, 1'b0};
      b_denz_r       <= {asz, 1'b0};
      b_sidex_r.neg  <= a_dhx_r[16] ^ a_sx_r[15];
      b_sidex_r.zero <= (a_sx_r == 16'sd0);
      b_sidez_r.neg  <= a_dhz_r[16] ^ a_sz_r[15];
      b_sidez_r.zero <= (a_sz_r == 16'sd0);
    end
  end

  // gradient dividers
  hvn_div #(
    .NW(hvn_pkg::GNUM_W), .DW(hvn_pkg::GDEN_W), .QW(hvn_pkg::GRAD_QW), .SW(GSW)
  ) u_gdiv_x (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(b_vld_r),
    .num(b_numx_r), .den(b_denx_r), .side(b_sidex_r),
    .out_vld(gx_vld), .quot(gx_q), .ovf(gx_ovf), .side_o(gx_side)
  );

  hvn_div #(
    .NW(hvn_pkg::GNUM_W), .DW(hvn_pkg::GDEN_W), .QW(hvn_pkg::GRAD_QW), .SW(GSW)
  ) u_gdiv_z (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(b_vld_r),
    .num(b_numz_r), .den(b_denz_r), .side(b_sidez_r),
    .out_vld(gz_vld), .quot(gz_q), .ovf(gz_ovf), .side_o(gz_side)
  );

  // Stage C: sign, saturation, zero span
  assign gx_res = grad_sat(gx_q, gx_ovf, gx_side);
  assign gz_res = grad_sat(gz_q, gz_ovf, gz_side);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= gx_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_dx_r  <= gx_res.g;
      c_dz_r  <= gz_res.g;
      c_sat_r <= gx_res.sat | gz_res.sat;
    end
  end

  // Stage D: squares
  assign sqx = c_dx_r * c_dx_r;
  assign sqz = c_dz_r * c_dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_sqx_r <= sqx[30:0];
      d_sqz_r <= sqz[30:0];
      d_dx_r  <= c_dx_r;
      d_dz_r  <= c_dz_r;
      d_sat_r <= c_sat_r;
    end
  end

  // Stage E: S = dx^2 + 1.0 + dz^2 in Q16.16
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (en) begin
      e_vld_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_s_r        <= hvn_pkg::SQ_W'(d_sqx_r) + hvn_pkg::SQ_W'(d_sqz_r) + hvn_pkg::ONE_Q16;
      e_side_r.dx  <= d_dx_r;
      e_side_r.dz  <= d_dz_r;
      e_side_r.sat <= d_sat_r;
    end
  end

  hvn_sqrt #(.SW(NSW)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(e_vld_r),
    .rad(e_s_r), .side(e_side_r),
    .out_vld(sq_vld), .root(sq_root), .side_o(sq_side)
  );

  // Stage F: normal divider operands with rounding bias
  always_comb begin
    gxe   = 17'(sq_side.dx);
    gze   = 17'(sq_side.dz);
    agx17 = gxe[16] ? -gxe : gxe;
    agz17 = gze[16] ? -gze : gze;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_numx_r <= (hvn_pkg::NNUM_W'(agx17[15:0]) << hvn_pkg::NX_SH)
                  + hvn_pkg::NNUM_W'(sq_root);
      f_numz_r <= (hvn_pkg::NNUM_W'(agz17[15:0]) << hvn_pkg::NX_SH)
                  + hvn_pkg::NNUM_W'(sq_root);
      f_numy_r <= (hvn_pkg::NNUM_W'(1) << hvn_pkg::NY_SH) + hvn_pkg::NNUM_W'(sq_root);
      f_den_r  <= {sq_root, 1'b0};
      // normal is -gradient
      f_negx_r <= !sq_side.dx[15];
      f_negz_r <= !sq_side.dz[15];
      f_sat_r  <= sq_side.sat;
    end
  end

  hvn_div #(
    .NW(hvn_pkg::NNUM_W), .DW(hvn_pkg::NDEN_W), .QW(hvn_pkg::NQ_W), .SW(1)
  ) u_ndiv_x (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(f_vld_r),
    .num(f_numx_r), .den(f_den_r), .side(f_negx_r),
    .out_vld(nx_vld), .quot(nx_q), .ovf(nx_ovf), .side_o(nx_neg)
  );

  hvn_div #(
    .NW(hvn_pkg::NNUM_W), .DW(hvn_pkg::NDEN_W), .QW(hvn_pkg::NQ_W), .SW(1)
  ) u_ndiv_y (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(f_vld_r),
    .num(f_numy_r), .den(f_den_r), .side(f_sat_r),
    .out_vld(ny_vld), .quot(ny_q), .ovf(ny_ovf), .side_o(ny_sat)
  );

  hvn_div #(
    .NW(hvn_pkg::NNUM_W), .DW(hvn_pkg::NDEN_W), .QW(hvn_pkg::NQ_W), .SW(1)
  ) u_ndiv_z (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(f_vld_r),
    .num(f_numz_r), .den(f_den_r), .side(f_negz_r),
    .out_vld(nz_vld), .quot(nz_q), .ovf(nz_ovf), .side_o(nz_neg)
  );

  // output register: clamp and apply sign
  assign cx = clamp_unit(nx_q);
  assign cy = clamp_unit(ny_q);
  assign cz = clamp_unit(nz_q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ny_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_nx_r  <= nx_neg ? -$signed({1'b0, cx}) : $signed({1'b0, cx});
      out_nz_r  <= nz_neg ? -$signed({1'b0, cz}) : $signed({1'b0, cz});
      out_ny_r  <= cy;
      out_sat_r <= ny_sat;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_normal_x        = out_nx_r;
  assign out_normal_y        = out_ny_r;
  assign out_normal_z        = out_nz_r;
  assign out_slope_saturated = out_sat_r;

  // parallel lanes stay in lockstep
  `ASSERT_ALWAYS(a_grad_lockstep, clk, rst_n, gx_vld == gz_vld, "gradient lanes out of step")
  `ASSERT_ALWAYS(a_norm_lockstep, clk, rst_n, (nx_vld == ny_vld) && (nz_vld == ny_vld),
                 "normal lanes out of step")
  // normal quotients always fit, since r is at least |g| * 2^23 and 2^23
  `ASSERT_IMPLY(a_norm_fit, clk, rst_n, ny_vld, !(nx_ovf || ny_ovf || nz_ovf),
                "normal quotient overflow")
  // a held output beat freezes the input side
  `ASSERT_IMPLY(a_hold_stall, clk, rst_n, out_valid && out_stall, in_stall,
                "input taken while output held")
  // y component of a unit normal is positive and at most one
  `ASSERT_IMPLY(a_ny_range, clk, rst_n, out_valid,
                (out_normal_y != 15'd0) && (out_normal_y <= hvn_pkg::UNIT_Q14),
                "normal_y out of range")

endmodule
